/* hdl/owk_pkg.sv */
// ----------------------------------------------------------------------------
// owk_pkg
// Shared types, constants and arithmetic helpers of the omni wheel
// kinematics unit.
// ----------------------------------------------------------------------------
package owk_pkg;

   localparam int VEC_W   = 32;
   localparam int ANG_W   = 16;
   localparam int KIND_W  = 3;
   localparam int CRD_W   = 34;   // CORDIC working width
   localparam int SUM_W   = 34;   // wheel sum a + b + c
   localparam int TERM_W  = 34;   // rounded Q2.30 term
   localparam int RTERM_W = 49;   // rounded radius term
   localparam int ACC_W   = 51;   // output accumulator
   localparam int QBITS   = 32;   // quotient bits of the rotation divide
   localparam int DEN_W   = 34;   // 3 * radius
   localparam int NUM_W   = 50;   // |sum| << 16 plus half the divisor

   // pipeline depth beyond the CORDIC iterations
   localparam int PIPE_EXTRA = 41;

   // transform kinds
   localparam logic [KIND_W-1:0] KIND_R2M = 3'd0;
   localparam logic [KIND_W-1:0] KIND_M2R = 3'd1;
   localparam logic [KIND_W-1:0] KIND_G2R = 3'd2;
   localparam logic [KIND_W-1:0] KIND_R2G = 3'd3;
   localparam logic [KIND_W-1:0] KIND_G2M = 3'd4;
   localparam logic [KIND_W-1:0] KIND_M2G = 3'd5;

   // Q2.30 coefficients
   localparam logic signed [31:0] Q30_K          = 32'sd929887697;
   localparam logic signed [31:0] Q30_I          = 32'sd619925131;
   localparam logic signed [31:0] Q30_TWO_THIRDS = 32'sd715827883;
   localparam logic signed [31:0] Q30_THIRD      = 32'sd357913941;
   localparam logic signed [31:0] Q30_HALF       = 32'sd536870912;
   localparam logic signed [31:0] Q30_ONE        = 32'sd1073741824;

   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] RADIUS_RESET = 32'd65536;

   localparam logic signed [VEC_W-1:0] OUT_MAX = 32'sh7fffffff;
   localparam logic signed [VEC_W-1:0] OUT_MIN = 32'sh80000000;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 51'sd2147483647;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -51'sd2147483648;

   // arctangent per step, 2^32 units per turn
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [VEC_W-1:0] a;
      logic signed [VEC_W-1:0] b;
      logic signed [VEC_W-1:0] c;
   } item_type;

   typedef struct packed {
      logic                    valid;
      item_type                item;
      logic signed [VEC_W-1:0] cos_q;
      logic signed [VEC_W-1:0] sin_q;
   } angle_type;

   typedef struct packed {
      logic                    valid;
      logic                    rot;
      logic signed [SUM_W-1:0] sum;
      logic signed [VEC_W-1:0] ra;
      logic signed [VEC_W-1:0] rb;
      logic signed [VEC_W-1:0] rc;
   } mix_type;

   typedef struct packed {
      logic                    valid;
      logic signed [VEC_W-1:0] a;
      logic signed [VEC_W-1:0] b;
      logic signed [VEC_W-1:0] c;
   } result_type;

   // Q2.30 coefficient times value, rounded half up
   function automatic logic signed [TERM_W-1:0] term_q30(input logic signed [31:0] k,
                                                         input logic signed [31:0] v);
      logic signed [63:0] p;
      p = k * v;
      p = p + (64'sd1 <<< 29);
      p = p >>> 30;
      return p[TERM_W-1:0];
   endfunction

   // product of two Q2.30 values, narrowed back to Q2.30
   function automatic logic signed [31:0] coef_mul(input logic signed [31:0] k,
                                                   input logic signed [31:0] v);
      logic signed [TERM_W-1:0] t;
      t = term_q30(k, v);
      return t[31:0];
   endfunction

   // unsigned Q16.16 radius times value, rounded half up
   function automatic logic signed [RTERM_W-1:0] term_rad(input logic [31:0] r,
                                                          input logic signed [31:0] v);
      logic signed [64:0] p;
      p = $signed({1'b0, r}) * v;
      p = p + (65'sd1 <<< 15);
      p = p >>> 16;
      return p[RTERM_W-1:0];
   endfunction

   function automatic logic signed [VEC_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [VEC_W-1:0] r;
      if (v > ACC_MAX) begin
         r = OUT_MAX;
      end else if (v < ACC_MIN) begin
         r = OUT_MIN;
      end else begin
         r = v[VEC_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hdl/owk_cordic.sv */
// ----------------------------------------------------------------------------
// owk_cordic
// Pipelined rotation-mode CORDIC: one iteration per stage, then quadrant
// fold-back. Carries the transaction payload alongside.
// ----------------------------------------------------------------------------
module owk_cordic #(
   parameter int STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  owk_pkg::item_type    in_item,
   input  logic signed [15:0]   in_heading,
   output owk_pkg::angle_type   out_angle
);
   import owk_pkg::*;

   typedef struct packed {
      logic                    valid;
      logic                    flip;
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [CRD_W-1:0] z;
      item_type                item;
   } stage_type;

   stage_type  init_s;
   stage_type  st_in [STEPS];
   stage_type  st_ff [STEPS];
   angle_type  angle_in;
   angle_type  angle_ff;

   logic [31:0] phase;
   logic        flip;
   logic [31:0] phase_fold;

   // fold second and third quadrant onto the first and fourth
   always_comb begin
      phase         = {in_heading, 16'h0000};
      flip          = phase[31] ^ phase[30];
      phase_fold    = {phase[31] ^ flip, phase[30:0]};
      init_s.valid  = in_valid;
      init_s.flip   = flip;
      init_s.x      = CORDIC_GAIN;
      init_s.y      = '0;
      init_s.z      = CRD_W'($signed(phase_fold));
      init_s.item   = in_item;
   end

   genvar i;
   for (i = 0; i < STEPS; i++) begin : g_step
      stage_type               prev;
      logic signed [CRD_W-1:0] dx;
      logic signed [CRD_W-1:0] dy;
      logic signed [CRD_W-1:0] at;

      if (i == 0) begin : g_first
         assign prev = init_s;
      end else begin : g_next
         assign prev = st_ff[i-1];
      end

      // rotate toward zero residual angle
      always_comb begin
         dx       = $signed(prev.y) >>> i;
         dy       = $signed(prev.x) >>> i;
         at       = $signed({2'b00, ATAN_TABLE[i]});
         st_in[i] = prev;
         if (!prev.z[CRD_W-1]) begin
            st_in[i].x = prev.x - dx;
            st_in[i].y = prev.y + dy;
            st_in[i].z = prev.z - at;
         end else begin
            st_in[i].x = prev.x + dx;
            st_in[i].y = prev.y - dy;
            st_in[i].z = prev.z + at;
         end
      end

      always_ff @(posedge clock) begin
         st_ff[i] <= st_in[i];
         if (reset) begin
            st_ff[i].valid <= 1'b0;
         end
      end
   end

   // undo the quadrant fold
   always_comb begin
      logic signed [CRD_W-1:0] cx;
      logic signed [CRD_W-1:0] sy;
      cx             = st_ff[STEPS-1].flip ? -st_ff[STEPS-1].x : st_ff[STEPS-1].x;
      sy             = st_ff[STEPS-1].flip ? -st_ff[STEPS-1].y : st_ff[STEPS-1].y;
      angle_in.valid = st_ff[STEPS-1].valid;
      angle_in.item  = st_ff[STEPS-1].item;
      angle_in.cos_q = cx[VEC_W-1:0];
      angle_in.sin_q = sy[VEC_W-1:0];
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
      if (reset) begin
         angle_ff.valid <= 1'b0;
      end
   end

   assign out_angle = angle_ff;

endmodule

/* hdl/owk_mix.sv */
// ----------------------------------------------------------------------------
// owk_mix
// Four-stage transform datapath: heading coefficients, per-kind matrix
// select, rounded products, sum and saturation.
// ----------------------------------------------------------------------------
module owk_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  owk_pkg::angle_type   in_angle,
   input  logic [31:0]          radius,
   output owk_pkg::mix_type     out_mix
);
   import owk_pkg::*;

   typedef struct packed {
      logic                    valid;
      item_type                item;
      logic signed [SUM_W-1:0] sum;
      logic signed [31:0]      cos_q;
      logic signed [31:0]      sin_q;
      logic signed [31:0]      k_cos;
      logic signed [31:0]      k_sin;
      logic signed [31:0]      h_cos;
      logic signed [31:0]      h_sin;
      logic signed [31:0]      i_cos;
      logic signed [31:0]      i_sin;
      logic signed [31:0]      t_cos;
      logic signed [31:0]      t_sin;
      logic signed [31:0]      w_cos;
      logic signed [31:0]      w_sin;
   } m1_type;

   typedef struct packed {
      logic                      valid;
      logic                      rflag;
      logic                      rot;
      logic signed [SUM_W-1:0]   sum;
      logic [2:0][VEC_W-1:0]     v;
      logic [2:0][2:0][31:0]     coef;
   } m2_type;

   typedef struct packed {
      logic                      valid;
      logic                      rot;
      logic signed [SUM_W-1:0]   sum;
      logic [2:0][2:0][TERM_W-1:0] t;
      logic [RTERM_W-1:0]        rt;
   } m3_type;

   m1_type  m1_in, m1_ff;
   m2_type  m2_in, m2_ff;
   m3_type  m3_in, m3_ff;
   mix_type m4_in, m4_ff;

   logic signed [ACC_W-1:0] acc [3];

   // scale heading sine and cosine by the wheel geometry
   always_comb begin
      m1_in.valid = in_angle.valid;
      m1_in.item  = in_angle.item;
      m1_in.sum   = SUM_W'(in_angle.item.a) + SUM_W'(in_angle.item.b)
                  + SUM_W'(in_angle.item.c);
      m1_in.cos_q = in_angle.cos_q;
      m1_in.sin_q = in_angle.sin_q;
      m1_in.k_cos = coef_mul(Q30_K, in_angle.cos_q);
      m1_in.k_sin = coef_mul(Q30_K, in_angle.sin_q);
      m1_in.h_cos = coef_mul(Q30_HALF, in_angle.cos_q);
      m1_in.h_sin = coef_mul(Q30_HALF, in_angle.sin_q);
      m1_in.i_cos = coef_mul(Q30_I, in_angle.cos_q);
      m1_in.i_sin = coef_mul(Q30_I, in_angle.sin_q);
      m1_in.t_cos = coef_mul(Q30_THIRD, in_angle.cos_q);
      m1_in.t_sin = coef_mul(Q30_THIRD, in_angle.sin_q);
      m1_in.w_cos = coef_mul(Q30_TWO_THIRDS, in_angle.cos_q);
      m1_in.w_sin = coef_mul(Q30_TWO_THIRDS, in_angle.sin_q);
   end

   // select the coefficient matrix of the transform kind
   always_comb begin
      m2_in.valid = m1_ff.valid;
      m2_in.sum   = m1_ff.sum;
      m2_in.v[0]  = m1_ff.item.a;
      m2_in.v[1]  = m1_ff.item.b;
      m2_in.v[2]  = m1_ff.item.c;
      m2_in.rflag = 1'b0;
      m2_in.rot   = 1'b0;
      m2_in.coef  = '0;
      case (m1_ff.item.kind)
         KIND_R2M: begin
            m2_in.coef[0][1] = Q30_ONE;
            m2_in.coef[1][0] = -Q30_K;
            m2_in.coef[1][1] = -Q30_HALF;
            m2_in.coef[2][0] = Q30_K;
            m2_in.coef[2][1] = -Q30_HALF;
            m2_in.rflag      = 1'b1;
         end
         KIND_M2R: begin
            m2_in.coef[0][1] = -Q30_I;
            m2_in.coef[0][2] = Q30_I;
            m2_in.coef[1][0] = Q30_TWO_THIRDS;
            m2_in.coef[1][1] = -Q30_THIRD;
            m2_in.coef[1][2] = -Q30_THIRD;
            m2_in.rot        = 1'b1;
         end
         KIND_G2R: begin
            m2_in.coef[0][0] = m1_ff.cos_q;
            m2_in.coef[0][1] = m1_ff.sin_q;
            m2_in.coef[1][0] = -m1_ff.sin_q;
            m2_in.coef[1][1] = m1_ff.cos_q;
            m2_in.coef[2][2] = Q30_ONE;
         end
         KIND_R2G: begin
            m2_in.coef[0][0] = m1_ff.cos_q;
            m2_in.coef[0][1] = -m1_ff.sin_q;
            m2_in.coef[1][0] = m1_ff.sin_q;
            m2_in.coef[1][1] = m1_ff.cos_q;
            m2_in.coef[2][2] = Q30_ONE;
         end
         KIND_G2M: begin
            m2_in.coef[0][0] = -m1_ff.sin_q;
            m2_in.coef[0][1] = m1_ff.cos_q;
            m2_in.coef[1][0] = m1_ff.h_sin - m1_ff.k_cos;
            m2_in.coef[1][1] = -m1_ff.k_sin - m1_ff.h_cos;
            m2_in.coef[2][0] = m1_ff.k_cos + m1_ff.h_sin;
            m2_in.coef[2][1] = m1_ff.k_sin - m1_ff.h_cos;
            m2_in.rflag      = 1'b1;
         end
         KIND_M2G: begin
            m2_in.coef[0][0] = -m1_ff.w_sin;
            m2_in.coef[0][1] = m1_ff.t_sin - m1_ff.i_cos;
            m2_in.coef[0][2] = m1_ff.i_cos + m1_ff.t_sin;
            m2_in.coef[1][0] = m1_ff.w_cos;
            m2_in.coef[1][1] = -m1_ff.i_sin - m1_ff.t_cos;
            m2_in.coef[1][2] = m1_ff.i_sin - m1_ff.t_cos;
            m2_in.rot        = 1'b1;
         end
         default: begin
            m2_in.coef = '0;
         end
      endcase
   end

   // form every rounded product term
   always_comb begin
      m3_in.valid = m2_ff.valid;
      m3_in.rot   = m2_ff.rot;
      m3_in.sum   = m2_ff.sum;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            m3_in.t[r][c] = term_q30($signed(m2_ff.coef[r][c]), $signed(m2_ff.v[c]));
         end
      end
      m3_in.rt = m2_ff.rflag ? term_rad(radius, $signed(m2_ff.v[2])) : '0;
   end

   // add the terms and clamp to the output range
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = ACC_W'($signed(m3_ff.t[r][0])) + ACC_W'($signed(m3_ff.t[r][1]))
                + ACC_W'($signed(m3_ff.t[r][2])) + ACC_W'($signed(m3_ff.rt));
      end
      m4_in.valid = m3_ff.valid;
      m4_in.rot   = m3_ff.rot;
      m4_in.sum   = m3_ff.sum;
      m4_in.ra    = sat32(acc[0]);
      m4_in.rb    = sat32(acc[1]);
      m4_in.rc    = sat32(acc[2]);
   end

   always_ff @(posedge clock) begin
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      m3_ff <= m3_in;
      m4_ff <= m4_in;
      if (reset) begin
         m1_ff.valid <= 1'b0;
         m2_ff.valid <= 1'b0;
         m3_ff.valid <= 1'b0;
         m4_ff.valid <= 1'b0;
      end
   end

   assign out_mix = m4_ff;

endmodule

/* hdl/owk_div.sv */
// ----------------------------------------------------------------------------
// owk_div
// Pipelined restoring divider for the rotation component:
// round((a + b + c) * 2^16 / (3 * radius)), one quotient bit per stage,
// then saturation and merge with the other components.
// ----------------------------------------------------------------------------
module owk_div (
   input  logic                  clock,
   input  logic                  reset,
   input  owk_pkg::mix_type      in_mix,
   input  logic [31:0]           radius,
   output owk_pkg::result_type   out_result
);
   import owk_pkg::*;

   typedef struct packed {
      logic                    valid;
      logic                    rot;
      logic                    neg;
      logic                    zero;
      logic [SUM_W-2:0]        mag;
      logic [DEN_W-1:0]        den;
      logic signed [VEC_W-1:0] ra;
      logic signed [VEC_W-1:0] rb;
      logic signed [VEC_W-1:0] rc;
   } sa_type;

   typedef struct packed {
      logic                    valid;
      logic                    rot;
      logic                    neg;
      logic                    zero;
      logic                    dz;
      logic [NUM_W-1:0]        num;
      logic [DEN_W-1:0]        den;
      logic signed [VEC_W-1:0] ra;
      logic signed [VEC_W-1:0] rb;
      logic signed [VEC_W-1:0] rc;
   } sb_type;

   typedef struct packed {
      logic                    valid;
      logic                    rot;
      logic                    neg;
      logic                    zero;
      logic                    dz;
      logic                    ovf;
      logic [DEN_W-1:0]        rem;
      logic [QBITS-1:0]        q;
      logic [QBITS-1:0]        nlo;
      logic [DEN_W-1:0]        den;
      logic signed [VEC_W-1:0] ra;
      logic signed [VEC_W-1:0] rb;
      logic signed [VEC_W-1:0] rc;
   } it_type;

   sa_type     sa_in, sa_ff;
   sb_type     sb_in, sb_ff;
   it_type     first_it;
   it_type     it_in [QBITS];
   it_type     it_ff [QBITS];
   result_type out_in, out_ff;

   // take magnitude of the wheel sum and build the divisor
   always_comb begin
      logic signed [SUM_W-1:0] abs_sum;
      abs_sum     = in_mix.sum[SUM_W-1] ? -in_mix.sum : in_mix.sum;
      sa_in.valid = in_mix.valid;
      sa_in.rot   = in_mix.rot;
      sa_in.neg   = in_mix.sum[SUM_W-1];
      sa_in.zero  = (in_mix.sum == '0);
      sa_in.mag   = abs_sum[SUM_W-2:0];
      sa_in.den   = DEN_W'(radius) + DEN_W'({radius, 1'b0});
      sa_in.ra    = in_mix.ra;
      sa_in.rb    = in_mix.rb;
      sa_in.rc    = in_mix.rc;
   end

   // add half the divisor for round-to-nearest
   always_comb begin
      sb_in.valid = sa_ff.valid;
      sb_in.rot   = sa_ff.rot;
      sb_in.neg   = sa_ff.neg;
      sb_in.zero  = sa_ff.zero;
      sb_in.dz    = (sa_ff.den == '0);
      sb_in.num   = NUM_W'({sa_ff.mag, 16'h0000}) + NUM_W'(sa_ff.den >> 1);
      sb_in.den   = sa_ff.den;
      sb_in.ra    = sa_ff.ra;
      sb_in.rb    = sa_ff.rb;
      sb_in.rc    = sa_ff.rc;
   end

   // seed the remainder with the bits above the quotient field
   always_comb begin
      first_it.valid = sb_ff.valid;
      first_it.rot   = sb_ff.rot;
      first_it.neg   = sb_ff.neg;
      first_it.zero  = sb_ff.zero;
      first_it.dz    = sb_ff.dz;
      first_it.ovf   = DEN_W'(sb_ff.num[NUM_W-1:QBITS]) >= sb_ff.den;
      first_it.rem   = DEN_W'(sb_ff.num[NUM_W-1:QBITS]);
      first_it.q     = '0;
      first_it.nlo   = sb_ff.num[QBITS-1:0];
      first_it.den   = sb_ff.den;
      first_it.ra    = sb_ff.ra;
      first_it.rb    = sb_ff.rb;
      first_it.rc    = sb_ff.rc;
   end

   genvar j;
   for (j = 0; j < QBITS; j++) begin : g_bit
      it_type           prev;
      logic [DEN_W:0]   trial;

      if (j == 0) begin : g_first
         assign prev = first_it;
      end else begin : g_next
         assign prev = it_ff[j-1];
      end

      // shift in one numerator bit, subtract when it fits
      always_comb begin
         trial    = {prev.rem, prev.nlo[QBITS-1-j]};
         it_in[j] = prev;
         if (trial >= {1'b0, prev.den}) begin
            it_in[j].rem          = DEN_W'(trial - {1'b0, prev.den});
            it_in[j].q[QBITS-1-j] = 1'b1;
         end else begin
            it_in[j].rem = trial[DEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         it_ff[j] <= it_in[j];
         if (reset) begin
            it_ff[j].valid <= 1'b0;
         end
      end
   end

   // apply sign, clamp, and merge into the result
   always_comb begin
      logic signed [VEC_W-1:0] qv;
      if (it_ff[QBITS-1].dz) begin
         if (it_ff[QBITS-1].zero) begin
            qv = '0;
         end else begin
            qv = it_ff[QBITS-1].neg ? OUT_MIN : OUT_MAX;
         end
      end else if (it_ff[QBITS-1].ovf || it_ff[QBITS-1].q[QBITS-1]) begin
         qv = it_ff[QBITS-1].neg ? OUT_MIN : OUT_MAX;
      end else begin
         qv = it_ff[QBITS-1].neg ? $signed(32'd0 - it_ff[QBITS-1].q)
                                 : $signed(it_ff[QBITS-1].q);
      end
      out_in.valid = it_ff[QBITS-1].valid;
      out_in.a     = it_ff[QBITS-1].ra;
      out_in.b     = it_ff[QBITS-1].rb;
      out_in.c     = it_ff[QBITS-1].rot ? qv : it_ff[QBITS-1].rc;
   end

   always_ff @(posedge clock) begin
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      out_ff <= out_in;
      if (reset) begin
         sa_ff.valid  <= 1'b0;
         sb_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end
   end

   assign out_result = out_ff;

endmodule

/* hdl/omni_wheel_kinematics_unit.sv */
// ----------------------------------------------------------------------------
// omni_wheel_kinematics_unit
// Kinematic transforms for a three omni wheel robot, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_kind, req_vec_a/b/c and req_heading with start high; the
//   transaction is taken at that clock edge when busy is low. busy is only
//   high during reset, so a new transaction can be issued every cycle.
//   The result appears on rsp_out_a/b/c with rsp_strobe high for exactly
//   one cycle. Throughput is one transaction per cycle outside reset;
//   results leave in issue order. Latency is set by the input register,
//   the CORDIC chain (one iteration per stage) and its fold-back stage,
//   four transform stages, and the rotation divider that resolves one
//   quotient bit per stage over 32 stages plus setup and output stages.
//   csr_wr_en/csr_wr_data write the wheel center radius (unsigned Q16.16);
//   write it only while no transaction is in flight.
//   Reset clears the pipeline (in-flight transactions are dropped) and sets
//   the radius to 1.0. The receiver has no back-pressure: every strobed
//   result must be captured in its cycle.
// ----------------------------------------------------------------------------
module omni_wheel_kinematics_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_kind,
   input  logic signed [31:0]  req_vec_a,
   input  logic signed [31:0]  req_vec_b,
   input  logic signed [31:0]  req_vec_c,
   input  logic signed [15:0]  req_heading,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_out_a,
   output logic signed [31:0]  rsp_out_b,
   output logic signed [31:0]  rsp_out_c,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data
);
   import owk_pkg::*;

   logic [31:0]        radius_in, radius_ff;
   logic               valid_in, valid_ff;
   item_type           item_in, item_ff;
   logic signed [15:0] heading_in, heading_ff;

   angle_type  angle;
   mix_type    mix;
   result_type result;

   // hold the radius register
   assign radius_in = csr_wr_en ? csr_wr_data : radius_ff;

   // capture the incoming transaction
   always_comb begin
      valid_in     = start;
      item_in.kind = req_kind;
      item_in.a    = req_vec_a;
      item_in.b    = req_vec_b;
      item_in.c    = req_vec_c;
      heading_in   = req_heading;
   end

   always_ff @(posedge clock) begin
      radius_ff  <= radius_in;
      valid_ff   <= valid_in;
      item_ff    <= item_in;
      heading_ff <= heading_in;
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         valid_ff  <= 1'b0;
      end
   end

   owk_cordic #(
      .STEPS      (CORDIC_STEPS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_ff),
      .in_item    (item_ff),
      .in_heading (heading_ff),
      .out_angle  (angle)
   );

   owk_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .in_angle (angle),
      .radius   (radius_ff),
      .out_mix  (mix)
   );

   owk_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_mix     (mix),
      .radius     (radius_ff),
      .out_result (result)
   );

   assign busy       = reset;
   assign rsp_strobe = result.valid;
   assign rsp_out_a  = result.a;
   assign rsp_out_b  = result.b;
   assign rsp_out_c  = result.c;

endmodule

/* hdl/owk_checker.sv */
// ----------------------------------------------------------------------------
// owk_checker
// Port-level checks of the kinematics unit: fixed latency and the
// kind-specific pass-through and zero results.
// ----------------------------------------------------------------------------
module owk_checker #(
   parameter int CORDIC_STEPS = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_kind,
   input logic signed [31:0] req_vec_c,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_out_a,
   input logic signed [31:0] rsp_out_b,
   input logic signed [31:0] rsp_out_c
);
   import owk_pkg::*;

   localparam int LAT = CORDIC_STEPS + PIPE_EXTRA;

   // every taken transaction yields a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result missing after fixed latency");

   // no result without a matching transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without a transaction");

   // unused kinds return a zero vector
   a_unused_kind: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind > KIND_M2G)) |->
      ##LAT (rsp_out_a == '0 && rsp_out_b == '0 && rsp_out_c == '0))
      else $error("unused kind gave nonzero result");

   // frame rotations keep the rotation component
   a_rot_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_G2R || req_kind == KIND_R2G)) |->
      ##LAT (rsp_out_c == $past(req_vec_c, LAT)))
      else $error("rotation component not passed through");

endmodule

bind omni_wheel_kinematics_unit owk_checker #(
   .CORDIC_STEPS (CORDIC_STEPS)
) u_owk_checker (.*);
